/* design/data_set_statistics_scores_defines.svh */
// Assertion macros used by the checker of the statistics block.
`ifndef DATA_SET_STATISTICS_SCORES_DEFINES_SVH
`define DATA_SET_STATISTICS_SCORES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dsss_pkg.sv */
// Package with types, constants and codes of the statistics block.
package dsss_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int IDX_OUT_W  = 6;
  localparam int VAL_OUT_W  = 16;
  localparam int Z_OUT_W    = 16;
  localparam int T_OUT_W    = 18;
  localparam int MEAN_OUT_W = 24;
  localparam int VAR_OUT_W  = 40;
  localparam int DEV_OUT_W  = 24;

  localparam int VAL_HI  = 32767;
  localparam int VAL_LO  = -32768;
  localparam int Z_HI    = 32767;
  localparam int T_HI    = 131071;
  localparam int T_LO    = -131072;
  localparam int MEAN_HI = 8388607;
  localparam int MEAN_LO = -8388608;

  // 50.0 in Q.8
  localparam int T_OFFSET = 12800;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_MUL,
    ST_SUB,
    ST_MEAN_GO,
    ST_MEAN_RUN,
    ST_VAR_GO,
    ST_VAR_RUN,
    ST_SQRT_GO,
    ST_SQRT_RUN,
    ST_READ,
    ST_DIFF,
    ST_Z_GO,
    ST_Z_RUN,
    ST_T_GO,
    ST_T_RUN,
    ST_EMIT
  } dsss_state_e;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_Z,
    DIV_T
  } div_sel_e;

  typedef struct packed {
    logic     clear;
    logic     mul;
    logic     sub;
    logic     div_go;
    div_sel_e div_sel;
    logic     sqrt_go;
    logic     rd_en;
    logic     diff;
    logic     emit;
  } dsss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic out_free;
    logic last_idx;
    logic zero_dev;
  } dsss_sts_t;

endpackage

/* design/dsss_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module dsss_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};
  assign rem_d  = qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* design/dsss_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module dsss_sqrt #(
  parameter int RAD_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);

  localparam int H     = RAD_W / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic [RAD_W-1:0] rad_q;
  logic [H+1:0]     rem_q;
  logic [H-1:0]     root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [H+3:0]     rem_sh, trial;
  logic             ge;

  assign rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = (H+4)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(H);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= (H+2)'(ge ? rem_sh - trial : rem_sh);
      root_q <= {root_q[H-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/dsss_ctrl.sv */
// Controller state machine that sequences loading, statistics and scoring.
module dsss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_valid_i,
  input  logic                last_sample_i,
  input  dsss_pkg::dsss_sts_t sts_i,
  output logic                sample_ready_o,
  output dsss_pkg::dsss_cmd_t cmd_o
);
  import dsss_pkg::*;

  dsss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:     if (sample_valid_i && last_sample_i) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_MUL;
      ST_MUL:      state_d = ST_SUB;
      ST_SUB:      state_d = ST_MEAN_GO;
      ST_MEAN_GO:  state_d = ST_MEAN_RUN;
      ST_MEAN_RUN: if (sts_i.div_done) state_d = ST_VAR_GO;
      ST_VAR_GO:   state_d = ST_VAR_RUN;
      ST_VAR_RUN:  if (sts_i.div_done) state_d = ST_SQRT_GO;
      ST_SQRT_GO:  state_d = ST_SQRT_RUN;
      ST_SQRT_RUN: if (sts_i.sqrt_done) state_d = ST_READ;
      ST_READ:     state_d = ST_DIFF;
      ST_DIFF:     state_d = sts_i.zero_dev ? ST_EMIT : ST_Z_GO;
      ST_Z_GO:     state_d = ST_Z_RUN;
      ST_Z_RUN:    if (sts_i.div_done) state_d = ST_T_GO;
      ST_T_GO:     state_d = ST_T_RUN;
      ST_T_RUN:    if (sts_i.div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.last_idx ? ST_LOAD : ST_READ;
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.div_sel  = DIV_MEAN;
    sample_ready_o = 1'b0;
    case (state_q)
      ST_LOAD:    sample_ready_o = 1'b1;
      ST_MUL:     cmd_o.mul = 1'b1;
      ST_SUB:     cmd_o.sub = 1'b1;
      ST_MEAN_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_MEAN;
      end
      ST_VAR_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_VAR;
      end
      ST_SQRT_GO: cmd_o.sqrt_go = 1'b1;
      ST_READ:    cmd_o.rd_en = 1'b1;
      ST_DIFF:    cmd_o.diff = 1'b1;
      ST_Z_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_Z;
      end
      ST_T_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_T;
      end
      ST_EMIT: begin
        cmd_o.emit  = sts_i.out_free;
        cmd_o.clear = sts_i.out_free && sts_i.last_idx;
      end
      default: ;
    endcase
  end

endmodule

/* design/dsss_datapath.sv */
// Datapath: sample store, accumulators, divider, square root and result register.
module dsss_datapath #(
  parameter int MAX_SAMPLES = dsss_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = dsss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  sample_valid_i,
  input  logic                                  sample_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  dsss_pkg::dsss_cmd_t                   cmd_i,
  output dsss_pkg::dsss_sts_t                   sts_o,
  input  logic                                  result_ready_i,
  output logic                                  result_valid_o,
  output logic [dsss_pkg::IDX_OUT_W-1:0]        element_index_o,
  output logic signed [dsss_pkg::VAL_OUT_W-1:0] sample_value_o,
  output logic signed [dsss_pkg::Z_OUT_W-1:0]   z_score_o,
  output logic signed [dsss_pkg::T_OUT_W-1:0]   t_score_o,
  output logic                                  is_even_o,
  output logic signed [dsss_pkg::MEAN_OUT_W-1:0] mean_value_o,
  output logic [dsss_pkg::VAR_OUT_W-1:0]        variance_value_o,
  output logic [dsss_pkg::DEV_OUT_W-1:0]        deviation_value_o,
  output logic                                  zero_spread_o,
  output logic                                  capacity_overflow_o,
  output logic                                  last_result_o
);
  import dsss_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SB + $clog2(MAX_SAMPLES);
  localparam int SQ_W   = 2 * SB;
  localparam int SSQ_W  = 2 * SB + CNT_W;
  localparam int M_W    = 2 * SB + 2 * CNT_W;
  localparam int NUM_RAW = 2 * SB + 2 * CNT_W + 10;
  localparam int NUM_W  = (NUM_RAW > 48) ? NUM_RAW : 48;
  localparam int DEN_W  = SB + 8;
  localparam int RAD_W  = NUM_W + 8;
  localparam int MEAN_W = SB + 9;
  localparam int D_W    = SB + 10;
  localparam int TV_W   = NUM_W + 2;

  // Sample store, written while loading and read once per result.
  logic signed [SB-1:0] mem [MAX_SAMPLES];
  logic signed [SB-1:0] rd_q;

  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SSQ_W-1:0]        ssq_q;
  logic [SQ_W-1:0]         sq_q;
  logic                    sq_vld_q;
  logic                    ovf_q;
  logic [IDX_W-1:0]        idx_q;

  logic [SSQ_W+CNT_W-1:0]  prod1_q;
  logic [2*SUM_W-1:0]      prod2_q;
  logic [2*CNT_W-1:0]      nsq_q;
  logic [M_W-1:0]          m_q;

  logic signed [MEAN_W-1:0] mean_q;
  logic [NUM_W-1:0]         var_q;
  logic [DEN_W-1:0]         dev_q;
  logic signed [D_W-1:0]    d_q;
  logic signed [Z_OUT_W-1:0] z_q;
  logic signed [T_OUT_W-1:0] t_q;

  div_sel_e                 div_sel_q;
  logic                     div_neg_q;

  logic                     accept, store;
  logic signed [SQ_W-1:0]   sq_s;
  logic [SUM_W-1:0]         smag;
  logic [D_W-1:0]           dmag;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_neg;
  logic                     div_done;
  logic [NUM_W-1:0]         quo;
  logic                     sqrt_done;
  logic [RAD_W/2-1:0]       root;
  logic signed [TV_W-1:0]   tv;
  logic                     out_vld_q;

  logic signed [31:0]       val_ext;
  logic signed [39:0]       mean_ext;
  logic [31:0]              dev_ext;

  assign accept = sample_valid_i && sample_ready_i;
  assign store  = accept && (cnt_q != CNT_W'(MAX_SAMPLES));
  assign sq_s   = sample_i * sample_i;
  assign smag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign dmag   = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);

  // Operand select for the shared divider.
  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_num = (NUM_W'(smag) << 8) + NUM_W'(cnt_q >> 1);
        div_den = DEN_W'(cnt_q);
        div_neg = sum_q[SUM_W-1];
      end
      DIV_VAR: begin
        div_num = (NUM_W'(m_q) << 8) + NUM_W'(nsq_q >> 1);
        div_den = DEN_W'(nsq_q);
        div_neg = 1'b0;
      end
      DIV_Z: begin
        div_num = (NUM_W'(dmag) << 12) + NUM_W'(dev_q >> 1);
        div_den = dev_q;
        div_neg = d_q[D_W-1];
      end
      default: begin
        div_num = (NUM_W'(dmag) << 11) + (NUM_W'(dmag) << 9) + NUM_W'(dev_q >> 1);
        div_den = dev_q;
        div_neg = d_q[D_W-1];
      end
    endcase
  end

  dsss_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  dsss_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .rad_i   (RAD_W'(var_q) << 8),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign tv = (div_neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo}))
              + TV_W'(T_OFFSET);

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[cnt_q[IDX_W-1:0]] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sum_q     <= '0;
      ssq_q     <= '0;
      sq_vld_q  <= 1'b0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= store;
      if (cmd_i.clear) begin
        cnt_q <= '0;
        sum_q <= '0;
        ssq_q <= '0;
        ovf_q <= 1'b0;
        idx_q <= '0;
      end else begin
        if (store) begin
          cnt_q <= cnt_q + 1'b1;
          sum_q <= sum_q + SUM_W'(sample_i);
        end else if (accept) begin
          ovf_q <= 1'b1;
        end
        if (sq_vld_q) begin
          ssq_q <= ssq_q + SSQ_W'(sq_q);
        end
        if (cmd_i.emit) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (result_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (store) begin
      sq_q <= SQ_W'(unsigned'(sq_s));
    end
    if (cmd_i.mul) begin
      prod1_q <= (SSQ_W+CNT_W)'(cnt_q) * (SSQ_W+CNT_W)'(ssq_q);
      prod2_q <= (2*SUM_W)'(smag) * (2*SUM_W)'(smag);
      nsq_q   <= (2*CNT_W)'(cnt_q) * (2*CNT_W)'(cnt_q);
    end
    if (cmd_i.sub) begin
      m_q <= M_W'(prod1_q - (SSQ_W+CNT_W)'(prod2_q));
    end
    if (cmd_i.div_go) begin
      div_sel_q <= cmd_i.div_sel;
      div_neg_q <= div_neg;
    end
    if (div_done) begin
      case (div_sel_q)
        DIV_MEAN: mean_q <= div_neg_q ? -$signed(MEAN_W'(quo)) : $signed(MEAN_W'(quo));
        DIV_VAR:  var_q  <= quo;
        DIV_Z: begin
          if (!div_neg_q) begin
            z_q <= (quo > NUM_W'(Z_HI)) ? Z_OUT_W'(Z_HI) : $signed(Z_OUT_W'(quo));
          end else begin
            z_q <= (quo > NUM_W'(Z_HI + 1)) ? Z_OUT_W'(-Z_HI - 1)
                                            : -$signed(Z_OUT_W'(quo));
          end
        end
        default: begin
          if (tv > TV_W'(T_HI)) begin
            t_q <= T_OUT_W'(T_HI);
          end else if (tv < TV_W'(T_LO)) begin
            t_q <= T_OUT_W'(T_LO);
          end else begin
            t_q <= T_OUT_W'(tv);
          end
        end
      endcase
    end
    if (sqrt_done) begin
      dev_q <= DEN_W'(root);
    end
    if (cmd_i.diff) begin
      d_q <= (D_W'(rd_q) <<< 8) - D_W'(mean_q);
      if (dev_q == '0) begin
        z_q <= '0;
        t_q <= T_OUT_W'(T_OFFSET);
      end
    end
  end

  // Output field saturation.
  assign val_ext  = 32'(rd_q);
  assign mean_ext = 40'(mean_q);
  assign dev_ext  = 32'(dev_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      element_index_o <= IDX_OUT_W'(idx_q);
      if (val_ext > 32'(VAL_HI)) begin
        sample_value_o <= VAL_OUT_W'(VAL_HI);
      end else if (val_ext < 32'(VAL_LO)) begin
        sample_value_o <= VAL_OUT_W'(VAL_LO);
      end else begin
        sample_value_o <= VAL_OUT_W'(val_ext);
      end
      z_score_o <= z_q;
      t_score_o <= t_q;
      is_even_o <= ~rd_q[0];
      if (mean_ext > 40'(MEAN_HI)) begin
        mean_value_o <= MEAN_OUT_W'(MEAN_HI);
      end else if (mean_ext < 40'(MEAN_LO)) begin
        mean_value_o <= MEAN_OUT_W'(MEAN_LO);
      end else begin
        mean_value_o <= MEAN_OUT_W'(mean_ext);
      end
      variance_value_o  <= (|var_q[NUM_W-1:VAR_OUT_W]) ? '1 : var_q[VAR_OUT_W-1:0];
      deviation_value_o <= (|dev_ext[31:DEV_OUT_W]) ? '1 : dev_ext[DEV_OUT_W-1:0];
      zero_spread_o       <= (dev_q == '0);
      capacity_overflow_o <= ovf_q;
      last_result_o       <= sts_o.last_idx;
    end
  end

  assign result_valid_o = out_vld_q;

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_vld_q || result_ready_i;
  assign sts_o.last_idx  = (CNT_W'(idx_q) + 1'b1) == cnt_q;
  assign sts_o.zero_dev  = (dev_q == '0);

endmodule

/* design/data_set_statistics_scores.sv */
// Top level: population mean, variance, deviation and per-sample z and T scores.
// Loading takes one sample transaction per cycle, back to back, while the store is open.
// After the closing sample the block works out mean, variance and square root in turn
// (NUM_W = 56, RAD_W = 64 by default) on the divider and root unit, one bit per cycle each.
// Each result then takes two divisions, for z and T, which are skipped with zero spread.
// Reset (rst_ni low, asynchronous) empties the set and the result register; store is kept.
module data_set_statistics_scores #(
  parameter int MAX_SAMPLES = dsss_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = dsss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   sample_valid_i,
  output logic                                   sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic                                   last_sample_i,
  output logic                                   result_valid_o,
  input  logic                                   result_ready_i,
  output logic [dsss_pkg::IDX_OUT_W-1:0]         element_index_o,
  output logic signed [dsss_pkg::VAL_OUT_W-1:0]  sample_value_o,
  output logic signed [dsss_pkg::Z_OUT_W-1:0]    z_score_o,
  output logic signed [dsss_pkg::T_OUT_W-1:0]    t_score_o,
  output logic                                   is_even_o,
  output logic signed [dsss_pkg::MEAN_OUT_W-1:0] mean_value_o,
  output logic [dsss_pkg::VAR_OUT_W-1:0]         variance_value_o,
  output logic [dsss_pkg::DEV_OUT_W-1:0]         deviation_value_o,
  output logic                                   zero_spread_o,
  output logic                                   capacity_overflow_o,
  output logic                                   last_result_o
);
  import dsss_pkg::*;

  // The controller steps through the phases: loading, sum of squares drain,
  // products, mean and variance divisions, square root, then one pass over the
  // store that produces one result transaction per stored sample.
  dsss_cmd_t cmd;
  dsss_sts_t sts;

  dsss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .last_sample_i  (last_sample_i),
    .sts_i          (sts),
    .sample_ready_o (sample_ready_o),
    .cmd_o          (cmd)
  );

  // The datapath owns the sample store, the accumulators, the shared divider,
  // the square root unit and the result register, which lets the last result
  // wait for its consumer while the next set already loads.
  dsss_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_valid_i      (sample_valid_i),
    .sample_ready_i      (sample_ready_o),
    .sample_i            (sample_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .result_ready_i      (result_ready_i),
    .result_valid_o      (result_valid_o),
    .element_index_o     (element_index_o),
    .sample_value_o      (sample_value_o),
    .z_score_o           (z_score_o),
    .t_score_o           (t_score_o),
    .is_even_o           (is_even_o),
    .mean_value_o        (mean_value_o),
    .variance_value_o    (variance_value_o),
    .deviation_value_o   (deviation_value_o),
    .zero_spread_o       (zero_spread_o),
    .capacity_overflow_o (capacity_overflow_o),
    .last_result_o       (last_result_o)
  );

endmodule

/* design/dsss_checker.sv */
// Port-level checker for the statistics block and its bind.
`include "data_set_statistics_scores_defines.svh"

module dsss_checker #(
  parameter int MAX_SAMPLES = dsss_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = dsss_pkg::SAMPLE_BITS_DEF
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   sample_valid_i,
  input logic                                   sample_ready_o,
  input logic signed [SAMPLE_BITS-1:0]          sample_i,
  input logic                                   last_sample_i,
  input logic                                   result_valid_o,
  input logic                                   result_ready_i,
  input logic [dsss_pkg::IDX_OUT_W-1:0]         element_index_o,
  input logic signed [dsss_pkg::VAL_OUT_W-1:0]  sample_value_o,
  input logic signed [dsss_pkg::Z_OUT_W-1:0]    z_score_o,
  input logic signed [dsss_pkg::T_OUT_W-1:0]    t_score_o,
  input logic                                   is_even_o,
  input logic signed [dsss_pkg::MEAN_OUT_W-1:0] mean_value_o,
  input logic [dsss_pkg::VAR_OUT_W-1:0]         variance_value_o,
  input logic [dsss_pkg::DEV_OUT_W-1:0]         deviation_value_o,
  input logic                                   zero_spread_o,
  input logic                                   capacity_overflow_o,
  input logic                                   last_result_o
);
  import dsss_pkg::*;

  logic in_acc;
  assign in_acc = sample_valid_i && sample_ready_o;

  // A stalled result transaction keeps its index, z score and last flag.
  `DSSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, result_valid_o && !result_ready_i, result_valid_o && $stable(element_index_o) && $stable(z_score_o) && $stable(last_result_o), "result changed while stalled")

  // No sample is taken while a result that is not the last one is pending.
  `DSSS_ASSERT_NOW(a_no_load_mid_run, clk_i, rst_ni, result_valid_o && !last_result_o, !sample_ready_o, "sample accepted during a result run")

  // A closing sample ends loading in the next cycle.
  `DSSS_ASSERT_NEXT(a_close_stops_load, clk_i, rst_ni, in_acc && last_sample_i, !sample_ready_o, "loading continued after closing sample")

  // Loading stays open after a sample that does not close the set.
  `DSSS_ASSERT_NEXT(a_load_stays_open, clk_i, rst_ni, in_acc && !last_sample_i, sample_ready_o, "loading closed without a closing sample")

  // Zero spread forces the default scores.
  `DSSS_ASSERT_NOW(a_zero_spread, clk_i, rst_ni, result_valid_o && zero_spread_o, (z_score_o == '0) && (t_score_o == T_OUT_W'(T_OFFSET)) && (deviation_value_o == '0), "zero spread without default scores")

endmodule

bind data_set_statistics_scores dsss_checker #(
  .MAX_SAMPLES (MAX_SAMPLES),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dsss_checker (.*);

/* tb/data_set_statistics_scores_tb.sv */
// Testbench for the sample-set statistics block: mean, variance, deviation and scores.
`timescale 1ns / 100ps

module data_set_statistics_scores_tb;
  import dsss_pkg::*;

  localparam int NSLOT         = MAX_SAMPLES_DEF;
  localparam int RANDOM_ITEMS  = 230;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 400;
  localparam int TAIL_CYCLES   = 300;

  // One result transaction, with every field at the width of its port.
  typedef struct packed {
    logic [IDX_OUT_W-1:0]         idx;
    logic signed [VAL_OUT_W-1:0]  value;
    logic signed [Z_OUT_W-1:0]    z;
    logic signed [T_OUT_W-1:0]    t;
    logic                         even;
    logic signed [MEAN_OUT_W-1:0] mean;
    logic [VAR_OUT_W-1:0]         var_q8;
    logic [DEV_OUT_W-1:0]         dev;
    logic                         flat;
    logic                         dropped;
    logic                         closing;
  } score_rec_t;

  // Scoreboard: keeps its own copy of the loaded set and predicts the score
  // transactions that a closing sample releases.
  class score_board;
    longint     set_vals[NSLOT];
    int         set_len;
    longint     set_sum;
    bit         set_dropped;
    score_rec_t pending[$];
    int         mismatches;
    int         results_seen;
    int         sets_closed;
    int         flat_sets;
    int         dropped_sets;

    function new();
      set_len = 0;
      set_sum = 0;
      set_dropped = 0;
      mismatches = 0;
      results_seen = 0;
      sets_closed = 0;
      flat_sets = 0;
      dropped_sets = 0;
    endfunction

    // Rounds num/den to nearest, ties away from zero; den is positive.
    function longint round_quot(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    // Floor of the square root, one result bit per pass.
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned acc;
      longint unsigned probe;
      acc = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
        if (v >= acc + probe) begin
          v = v - (acc + probe);
          acc = (acc >> 1) + probe;
        end else begin
          acc = acc >> 1;
        end
        probe = probe >> 2;
      end
      return acc;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_sample(logic signed [15:0] x, bit closes);
      longint          n;
      longint          mean_q8;
      longint unsigned sq_sum;
      longint unsigned numer;
      longint unsigned den;
      longint unsigned var_q8;
      longint unsigned dev_q8;
      longint          d;
      longint          zv;
      longint          tv;
      score_rec_t      rec;
      if (set_len < NSLOT) begin
        set_vals[set_len] = longint'(x);
        set_len++;
        set_sum += longint'(x);
      end else begin
        set_dropped = 1;
      end
      if (!closes) return;

      n = set_len;
      sq_sum = 0;
      for (int k = 0; k < set_len; k++) sq_sum += set_vals[k] * set_vals[k];
      mean_q8 = round_quot(set_sum * 256, n);
      numer = n * sq_sum - set_sum * set_sum;
      den = n * n;
      var_q8 = (numer / den) * 256 + ((numer % den) * 256 + den / 2) / den;
      dev_q8 = root_floor(var_q8 << 8);

      for (int k = 0; k < set_len; k++) begin
        zv = 0;
        tv = T_OFFSET;
        if (dev_q8 != 0) begin
          d  = set_vals[k] * 256 - mean_q8;
          zv = round_quot(d * 4096, dev_q8);
          tv = round_quot(d * 2560, dev_q8) + T_OFFSET;
        end
        rec.idx     = IDX_OUT_W'(k);
        rec.value   = VAL_OUT_W'(clip(set_vals[k], VAL_LO, VAL_HI));
        rec.z       = Z_OUT_W'(clip(zv, -32768, Z_HI));
        rec.t       = T_OUT_W'(clip(tv, T_LO, T_HI));
        rec.even    = (set_vals[k] % 2) == 0;
        rec.mean    = MEAN_OUT_W'(clip(mean_q8, MEAN_LO, MEAN_HI));
        rec.var_q8  = VAR_OUT_W'((var_q8 > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : var_q8);
        rec.dev     = DEV_OUT_W'((dev_q8 > 64'hFF_FFFF) ? 64'hFF_FFFF : dev_q8);
        rec.flat    = dev_q8 == 0;
        rec.dropped = set_dropped;
        rec.closing = (k + 1 == set_len);
        pending.push_back(rec);
      end
      sets_closed++;
      if (dev_q8 == 0) flat_sets++;
      if (set_dropped) dropped_sets++;
      set_len = 0;
      set_sum = 0;
      set_dropped = 0;
    endfunction

    function void check_result(score_rec_t got);
      score_rec_t want;
      string      bad;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction %p", got);
        return;
      end
      want = pending.pop_front();
      bad = "";
      if (got.idx     !== want.idx)     bad = {bad, " element_index"};
      if (got.value   !== want.value)   bad = {bad, " sample_value"};
      if (got.z       !== want.z)       bad = {bad, " z_score"};
      if (got.t       !== want.t)       bad = {bad, " t_score"};
      if (got.even    !== want.even)    bad = {bad, " is_even"};
      if (got.mean    !== want.mean)    bad = {bad, " mean_value"};
      if (got.var_q8  !== want.var_q8)  bad = {bad, " variance_value"};
      if (got.dev     !== want.dev)     bad = {bad, " deviation_value"};
      if (got.flat    !== want.flat)    bad = {bad, " zero_spread"};
      if (got.dropped !== want.dropped) bad = {bad, " capacity_overflow"};
      if (got.closing !== want.closing) bad = {bad, " last_result"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: mismatch in%s", bad);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         sample_valid;
  logic                         sample_ready;
  logic signed [15:0]           sample;
  logic                         last_sample;
  logic                         result_valid;
  logic                         result_ready;
  score_rec_t                   result;

  score_board                   board;
  bit                           no_idle;     // set for stretches without gaps
  bit                           hold_req;    // asks the receiver for one long hold
  bit                           hold_done;
  int                           sent_items;
  int                           cycles;

  data_set_statistics_scores u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .sample_valid_i      (sample_valid),
    .sample_ready_o      (sample_ready),
    .sample_i            (sample),
    .last_sample_i       (last_sample),
    .result_valid_o      (result_valid),
    .result_ready_i      (result_ready),
    .element_index_o     (result.idx),
    .sample_value_o      (result.value),
    .z_score_o           (result.z),
    .t_score_o           (result.t),
    .is_even_o           (result.even),
    .mean_value_o        (result.mean),
    .variance_value_o    (result.var_q8),
    .deviation_value_o   (result.dev),
    .zero_spread_o       (result.flat),
    .capacity_overflow_o (result.dropped),
    .last_result_o       (result.closing)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("ERROR: timeout after %0d cycles", cycles);
        $display("data_set_statistics_scores test failed");
        $finish;
      end
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the
  // block's own updates of that edge land.
  always @(posedge clk) begin
    if (rst_n && result_valid && result_ready) board.check_result(result);
  end

  // Offers one sample transaction and holds it until the block takes it.
  // Valid and payload only change at the falling edge.
  task automatic send_sample(logic signed [15:0] x, bit closes);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = x;
    last_sample = closes;
    do @(posedge clk); while (!sample_ready);
    board.note_sample(x, closes);
    sent_items++;
    @(negedge clk);
    sample_valid = 1'b0;
  endtask

  // Draws one random sample for a set of the given flavor.
  function automatic logic signed [15:0] draw_sample(int flavor, logic signed [15:0] base);
    case (flavor)
      0:       return 16'($urandom);
      1:       return base + $signed(16'($urandom_range(0, 15))) - 16'sd8;
      2:       return base;
      default: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3))
                                            : 16'sh8000 + 16'($urandom_range(0, 3));
    endcase
  endfunction

  // Sends a whole set of random samples, the last one closing it.
  task automatic send_set(int len, int flavor);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int k = 0; k < len; k++) send_sample(draw_sample(flavor, base), k == len - 1);
  endtask

  // Receiver: draws a wait before every result transaction and once holds
  // ready low for a long stretch so that the block backs up into its input.
  initial begin
    int gap;
    result_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        result_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        result_ready = 1'b0;
        @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    int len;
    int flavor;
    int drain;
    board = new();
    rst_n = 1'b0;
    sample_valid = 1'b0;
    sample = '0;
    last_sample = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    sent_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed sets: two single samples (no spread), the two extremes together,
    // a constant set, an alternating pair set and a one-sided outlier.
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    for (int k = 0; k < 4; k++) send_sample(-16'sd5, k == 3);
    for (int k = 0; k < 4; k++) send_sample(k[0] ? 16'sd1 : 16'sd0, k == 3);
    for (int k = 0; k < 8; k++) send_sample(k == 7 ? 16'sh7FFF : 16'sh8000, k == 7);

    // Random sets: mostly short, now and then one of NSLOT - 1 to NSLOT + 3 samples that
    // can fill the store and spill over, with the closing sample itself dropped in some.
    while (sent_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (sent_items > 60) hold_req = 1'b1;
      flavor = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(NSLOT - 1, NSLOT + 3);
      else len = $urandom_range(1, 8);
      send_set(len, flavor);
    end
    no_idle = 1'b0;

    drain = 0;
    while (board.pending.size() != 0) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples in %0d sets, %0d score transactions checked.",
             sent_items, board.sets_closed, board.results_seen);
    $display("Sets without spread: %0d, sets with dropped samples: %0d, mismatches: %0d.",
             board.flat_sets, board.dropped_sets, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("data_set_statistics_scores test passed");
    end else begin
      $display("data_set_statistics_scores test failed");
    end
    $finish;
  end

endmodule
